// ===== rtl/fmps_pkg.sv =====
// Package of shared constants and types for the FIFO and max priority server.
package fmps_pkg;

  localparam int unsigned DefCapacity = 1024;
  localparam int unsigned TieShift    = 17;
  localparam int unsigned AmountW     = 32;
  localparam int unsigned KeyW        = AmountW + TieShift;
  localparam int unsigned IdW         = 11;
  localparam int unsigned OpW         = 2;
  localparam int unsigned StatusW     = 2;

  localparam logic [OpW-1:0] OpArrive     = 2'd0;
  localparam logic [OpW-1:0] OpServeOld   = 2'd1;
  localparam logic [OpW-1:0] OpServeBest  = 2'd2;

  localparam logic [StatusW-1:0] StAccepted = 2'd0;
  localparam logic [StatusW-1:0] StServed   = 2'd1;
  localparam logic [StatusW-1:0] StEmpty    = 2'd2;
  localparam logic [StatusW-1:0] StFull     = 2'd3;

  typedef enum logic [2:0] {
    CmdNone  = 3'b001,
    CmdWrite = 3'b010,
    CmdOld   = 3'b100
  } cmd_e;

  // Classified request handed from the front part to the back part.
  typedef struct packed {
    cmd_e              cmd;
    logic [AmountW-1:0] amount;
    logic [StatusW-1:0] status;
    logic [IdW-1:0]     id;
  } job_t;

endpackage

// ===== rtl/fmps_if.sv =====
// Valid/ready channel interface carrying one request or one result.
interface fmps_if #(
  parameter int unsigned W = 1
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/fmps_back.sv =====
// Back part: walks the max tree and the leaf memory to carry out one classified request.
module fmps_back import fmps_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity,
  parameter int unsigned LW = $clog2(CAPACITY)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  job_t                job_i,
  output logic                job_ready_o,
  output logic                res_valid_o,
  output logic [StatusW-1:0]  res_status_o,
  output logic [IdW-1:0]      res_id_o,
  input  logic                res_ready_i,
  output logic [KeyW-1:0]     root_o
);

  localparam int unsigned NW = LW + 1;

  typedef enum logic [6:0] {
    SIdle  = 7'b0000001,
    SClear = 7'b0000010,
    SScan  = 7'b0000100,
    SScanW = 7'b0001000,
    SUp    = 7'b0010000,
    SUpW   = 7'b0100000,
    SOut   = 7'b1000000
  } state_e;

  logic [KeyW-1:0] tree_mem [2*CAPACITY];
  logic [KeyW-1:0] rd_q;
  logic [NW-1:0]   rd_addr;
  logic            wr_en;
  logic [NW-1:0]   wr_addr;
  logic [KeyW-1:0] wr_data;

  state_e          state_q, state_d;
  logic [NW-1:0]   node_q, node_d;
  logic [KeyW-1:0] cur_q, cur_d;
  logic [LW:0]     ptr_q, ptr_d;
  logic [StatusW-1:0] st_q, st_d;
  logic [IdW-1:0]  id_q, id_d;
  logic [KeyW-1:0] root_q, root_d;
  logic [KeyW-1:0] big;

  always_ff @(posedge clk_i) begin
    if (wr_en) tree_mem[wr_addr] <= wr_data;
    rd_q <= tree_mem[rd_addr];
  end

  assign big = (rd_q > cur_q) ? rd_q : cur_q;

  always_comb begin
    state_d = state_q; node_d = node_q; cur_d = cur_q; ptr_d = ptr_q;
    st_d = st_q; id_d = id_q; root_d = root_q;
    wr_en = 1'b0; wr_addr = node_q; wr_data = cur_q; rd_addr = node_q ^ NW'(1);
    job_ready_o = 1'b0;
    unique case (state_q)
      SClear: begin
        wr_en = 1'b1; wr_data = '0;
        node_d = node_q + NW'(1);
        if (node_q == NW'(2*CAPACITY-1)) state_d = SIdle;
      end
      SIdle: begin
        job_ready_o = 1'b1;
        st_d = job_i.status; id_d = job_i.id;
        if (job_valid_i) begin
          unique case (job_i.cmd)
            CmdWrite: begin
              node_d = NW'(CAPACITY) + NW'(job_i.id - IdW'(1));
              cur_d = (job_i.status == StAccepted) ?
                      {job_i.amount, TieShift'(CAPACITY + 1 - int'(job_i.id))} : '0;
              state_d = SUp;
            end
            CmdOld: begin
              node_d = NW'(CAPACITY) + NW'(ptr_q[LW-1:0]);
              state_d = SScan;
            end
            default: state_d = SOut;
          endcase
        end
      end
      SScan: begin
        rd_addr = node_q; state_d = SScanW;
      end
      SScanW: begin
        if (rd_q != '0) begin
          id_d = IdW'(ptr_q) + IdW'(1); cur_d = '0; state_d = SUp;
        end else begin
          ptr_d = ptr_q + NW'(1); node_d = node_q + NW'(1); state_d = SScan;
        end
      end
      SUp: begin
        wr_en = 1'b1;
        if (node_q == NW'(1)) begin
          root_d = cur_q; state_d = SOut;
        end else state_d = SUpW;
      end
      SUpW: begin
        cur_d = big; node_d = node_q >> 1; state_d = SUp;
      end
      SOut: if (res_ready_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear; node_q <= '0; ptr_q <= '0; root_q <= '0;
    end else begin
      state_q <= state_d; node_q <= node_d; ptr_q <= ptr_d; root_q <= root_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; st_q <= st_d; id_q <= id_d;
  end

  assign res_valid_o  = (state_q == SOut);
  assign res_status_o = st_q;
  assign res_id_o     = id_q;
  assign root_o       = root_q;

endmodule

// ===== rtl/fmps_front.sv =====
// Front part: classifies each request against the root and the arrival counter.
module fmps_front import fmps_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  logic [OpW-1:0]  opcode_i,
  input  logic [AmountW-1:0] amount_i,
  output logic            req_ready_o,
  input  logic [KeyW-1:0] root_i,
  output logic            job_valid_o,
  output job_t            job_o,
  input  logic            job_ready_i
);

  localparam int unsigned CW = $clog2(CAPACITY + 2);

  logic          full_q;
  logic [CW-1:0] next_q;
  logic          pend_q;
  job_t          job_q, job_d;
  logic [TieShift-1:0] tie;

  assign tie = root_i[TieShift-1:0];
  assign req_ready_o = !pend_q && !full_q;
  assign job_valid_o = full_q;
  assign job_o = job_q;

  always_comb begin
    job_d = job_q;
    job_d.amount = amount_i; job_d.cmd = CmdNone;
    job_d.status = StEmpty; job_d.id = '0;
    unique case (opcode_i)
      OpArrive: begin
        if (next_q > CW'(CAPACITY)) job_d.status = StFull;
        else begin
          job_d.cmd = CmdWrite; job_d.status = StAccepted; job_d.id = IdW'(next_q);
        end
      end
      OpServeOld: if (root_i != '0) begin
        job_d.cmd = CmdOld; job_d.status = StServed;
      end
      OpServeBest: if (root_i != '0 && tie != '0 && tie <= TieShift'(CAPACITY)) begin
        job_d.cmd = CmdWrite; job_d.status = StServed;
        job_d.id = IdW'(TieShift'(CAPACITY + 1) - tie);
      end
      default: ;
    endcase
  end

  // pend_q blocks the next request until the back part's result has been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0; next_q <= CW'(1); pend_q <= 1'b0;
    end else begin
      if (req_valid_i && req_ready_o) begin
        full_q <= 1'b1; pend_q <= 1'b1;
        if (job_d.status == StAccepted) next_q <= next_q + CW'(1);
      end else if (full_q && job_ready_i) begin
        full_q <= 1'b0;
      end else if (!full_q && job_ready_i && pend_q) begin
        pend_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) job_q <= job_d;
  end

endmodule

// ===== rtl/fifo_and_max_priority_server.sv =====
// Top level of the FIFO and max priority server.
// Customers arrive with a 32-bit value and receive numbers from 1; a serve-oldest request
// removes the earliest waiting customer, a serve-best request the one with the largest value,
// ties going to the earliest. A front part classifies each request using the tree root and
// the arrival count; a one-entry queue hands it to a back part that, for an arrival or a
// served customer, rewrites one leaf-to-root path in the tree memory, a level at a time; a
// serve-oldest request first scans the leaves from the oldest pointer, skipping served ones.
// A request that only reports empty or full writes nothing. One request is in flight at a
// time, and a stalled result holds it. After reset a clearing pass zeroes the tree memory;
// one request may be accepted during the pass, and it is carried out once the pass ends.
module fifo_and_max_priority_server import fmps_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  fmps_if.sink   req_i,
  fmps_if.source res_o
);

  logic            job_valid, job_ready;
  job_t            job;
  logic [KeyW-1:0] root;
  logic            fr_ready;

  // The back part only takes a job once it sits idle, which covers the clearing pass.
  fmps_front #(.CAPACITY(CAPACITY)) u_front (
    .clk_i, .rst_ni,
    .req_valid_i (req_i.valid),
    .opcode_i    (req_i.data[OpW+AmountW-1:AmountW]),
    .amount_i    (req_i.data[AmountW-1:0]),
    .req_ready_o (fr_ready),
    .root_i      (root),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_ready_i (job_ready)
  );

  assign req_i.ready = fr_ready;

  fmps_back #(.CAPACITY(CAPACITY)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i  (job_valid),
    .job_i        (job),
    .job_ready_o  (job_ready),
    .res_valid_o  (res_o.valid),
    .res_status_o (res_o.data[StatusW+IdW-1:IdW]),
    .res_id_o     (res_o.data[IdW-1:0]),
    .res_ready_i  (res_o.ready),
    .root_o       (root)
  );

endmodule
